// File: sv/windowed_difference_velocity_core_defines.svh
// Assertion macros for the windowed difference velocity core.
`ifndef WINDOWED_DIFFERENCE_VELOCITY_CORE_DEFINES_SVH
`define WINDOWED_DIFFERENCE_VELOCITY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WDV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WDV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WDV_ASSERT(label, clk, rst_n, prop, msg)
`define WDV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: sv/wdv_pkg.sv
// ---------------------------------------------------------------------------
// wdv_pkg
// Shared types and constants of the windowed difference velocity core.
// ---------------------------------------------------------------------------
package wdv_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int TIME_W = 48;
    localparam int Q_W = 32;

    localparam logic [23:0] WINDOW_RESET = 24'd100000;
    localparam logic [6:0] LIMIT_RESET = 7'd50;
    localparam logic [TIME_W-1:0] DT_MIN_US = 48'd1000;
    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        SRC_SUPPLIED = 2'd0,
        SRC_DIFF = 2'd1,
        SRC_FEW = 2'd2,
        SRC_SMALL_DT = 2'd3
    } src_t;

    // Item queued from the front part to the back part.
    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic signed [Q_W-1:0] px;
        logic signed [Q_W-1:0] py;
        logic signed [Q_W-1:0] pz;
        logic vv;
        logic signed [Q_W-1:0] vx;
        logic signed [Q_W-1:0] vy;
        logic signed [Q_W-1:0] vz;
    } item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] px;
        logic signed [Q_W-1:0] py;
        logic signed [Q_W-1:0] pz;
        logic signed [Q_W-1:0] vx;
        logic signed [Q_W-1:0] vy;
        logic signed [Q_W-1:0] vz;
        src_t src;
        logic sat;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PICK_RD,
        ST_PICK_WAIT,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

endpackage

// File: sv/windowed_difference_velocity_core.sv
// A supplied velocity goes straight to the result; else the oldest samples are dropped to fit
// history_limit, the new one is stored and, unless alone, the history is scanned from the
// oldest entry for the first inside the window; dt under 1 ms gives zero velocity, else each
// axis is differenced and divided in turn. One request is computed at a time; the two-entry
// queue keeps accepting while the back part works. Reset (rst_n, asynchronous, active low)
// empties the history and restores window_us and history_limit to 100000 and 50.
// ---------------------------------------------------------------------------
// windowed_difference_velocity_core
// Passes position through and, when no valid velocity comes with the request,
// supplies a windowed finite-difference velocity (zero for a lone sample or dt < 1 ms).
// ---------------------------------------------------------------------------
module windowed_difference_velocity_core
    import wdv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_W-1:0]     timestamp_us,
    input  logic signed [Q_W-1:0] pos_x,
    input  logic signed [Q_W-1:0] pos_y,
    input  logic signed [Q_W-1:0] pos_z,
    input  logic                  vel_valid,
    input  logic signed [Q_W-1:0] vel_in_x,
    input  logic signed [Q_W-1:0] vel_in_y,
    input  logic signed [Q_W-1:0] vel_in_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [Q_W-1:0] out_pos_x,
    output logic signed [Q_W-1:0] out_pos_y,
    output logic signed [Q_W-1:0] out_pos_z,
    output logic signed [Q_W-1:0] vel_x,
    output logic signed [Q_W-1:0] vel_y,
    output logic signed [Q_W-1:0] vel_z,
    output logic [1:0]            vel_source,
    output logic                  vel_saturated
);

    logic [23:0] window_reg;
    logic [6:0] limit_reg;
    item_t in_item, q_item;
    logic q_valid, q_ready;
    result_t res;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW)
            begin
                window_reg <= cfg_data;
            end
            else
            begin
                limit_reg <= cfg_data[6:0];
            end
        end
    end

    // The front part packs the request into the queue.
    assign in_item = '{t: timestamp_us, px: pos_x, py: pos_y, pz: pos_z, vv: vel_valid,
                       vx: vel_in_x, vy: vel_in_y, vz: vel_in_z};

    wdv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    wdv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_us     (window_reg),
        .history_limit (limit_reg),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_res       (res)
    );

    assign out_pos_x = res.px;
    assign out_pos_y = res.py;
    assign out_pos_z = res.pz;
    assign vel_x = res.vx;
    assign vel_y = res.vy;
    assign vel_z = res.vz;
    assign vel_source = res.src;
    assign vel_saturated = res.sat;

endmodule

// File: sv/wdv_queue.sv
// ---------------------------------------------------------------------------
// wdv_queue
// Two-entry queue between the accepting front part and the compute back part.
// ---------------------------------------------------------------------------
module wdv_queue
    import wdv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic do_wr, do_rd;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item = mem_reg[rd_ptr_reg];
    assign do_wr = in_valid && in_ready;
    assign do_rd = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

// File: sv/wdv_divider.sv
// ---------------------------------------------------------------------------
// wdv_divider
// Restoring divider, one quotient bit a cycle, with rounding and saturation.
// ---------------------------------------------------------------------------
module wdv_divider
    import wdv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [53:0]        num,
    input  logic [TIME_W:0]    den,
    input  logic               neg,
    output logic               done,
    output logic signed [Q_W-1:0] quo,
    output logic               sat
);

    // num = 2*mag + dt (at most 54 bits), den = 2*dt.
    logic [53:0] q_reg, q_next;
    logic [TIME_W+1:0] r_reg, r_next;
    logic [5:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic [TIME_W+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[TIME_W:0], q_reg[53]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            n_next = 6'd54;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[52:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[52:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        n_reg <= n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign done = !busy_reg && !start;

    always_comb
    begin
        sat = 1'b0;
        quo = '0;
        if (!neg)
        begin
            if (q_reg > 54'h7FFFFFFF)
            begin
                sat = 1'b1;
                quo = 32'sh7FFFFFFF;
            end
            else
            begin
                quo = q_reg[31:0];
            end
        end
        else
        begin
            if (q_reg > 54'h80000000)
            begin
                sat = 1'b1;
                quo = 32'sh80000000;
            end
            else
            begin
                quo = -q_reg[31:0];
            end
        end
    end

endmodule

// File: sv/wdv_back.sv
// ---------------------------------------------------------------------------
// wdv_back
// History ring, window scan and per-axis difference quotient sequencer.
// ---------------------------------------------------------------------------
module wdv_back
    import wdv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] window_us,
    input  logic [6:0]  history_limit,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

`include "windowed_difference_velocity_core_defines.svh"

    logic [Q_W-1:0] mem_x [HISTORY_DEPTH];
    logic [Q_W-1:0] mem_y [HISTORY_DEPTH];
    logic [Q_W-1:0] mem_z [HISTORY_DEPTH];
    logic [TIME_W-1:0] mem_t [HISTORY_DEPTH];

    state_t state_reg, state_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic [1:0] axis_reg, axis_next;
    item_t cur_reg, cur_next;
    result_t res_reg, res_next;
    result_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [Q_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [TIME_W-1:0] rd_t_reg;

    logic [CNT_W-1:0] lim;
    logic [TIME_W-1:0] dt_reg, dt_next;
    logic signed [Q_W:0] d_reg, d_next;
    logic [Q_W-1:0] dmag;
    logic [51:0] mag_reg, mag_next;
    logic [53:0] div_num;
    logic div_start, div_done, div_sat;
    logic signed [Q_W-1:0] div_quo;
    logic neg_reg, neg_next;

    always_comb
    begin
        if (history_limit > 7'(HISTORY_DEPTH))
        begin
            lim = CNT_W'(HISTORY_DEPTH);
        end
        else if (history_limit < 7'd1)
        begin
            lim = CNT_W'(1);
        end
        else
        begin
            lim = CNT_W'(history_limit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= cur_reg.px;
            mem_y[wr_addr] <= cur_reg.py;
            mem_z[wr_addr] <= cur_reg.pz;
            mem_t[wr_addr] <= cur_reg.t;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_z_reg <= mem_z[rd_addr];
        rd_t_reg <= mem_t[rd_addr];
    end

    wdv_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({dt_reg, 1'b0}),
        .neg   (neg_reg),
        .done  (div_done),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    assign div_num = {1'b0, mag_reg, 1'b0} + {6'd0, dt_reg};
    assign dmag = d_reg[Q_W] ? Q_W'(-d_reg) : d_reg[Q_W-1:0];
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res = out_reg;

    always_comb
    begin
        state_next = state_reg;
        oldest_next = oldest_reg;
        count_next = count_reg;
        k_next = k_reg;
        pick_next = pick_reg;
        axis_next = axis_reg;
        cur_next = cur_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        dt_next = dt_reg;
        d_next = d_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        wr_en = 1'b0;
        wr_addr = IDX_W'(oldest_reg + IDX_W'(count_reg));
        rd_addr = IDX_W'(oldest_reg + IDX_W'(k_reg));
        div_start = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = in_item;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                res_next.px = cur_reg.px;
                res_next.py = cur_reg.py;
                res_next.pz = cur_reg.pz;
                res_next.sat = 1'b0;
                if (cur_reg.vv)
                begin
                    res_next.vx = cur_reg.vx;
                    res_next.vy = cur_reg.vy;
                    res_next.vz = cur_reg.vz;
                    res_next.src = SRC_SUPPLIED;
                    state_next = ST_OUT;
                end
                else if (count_reg >= lim)
                begin
                    // Drop one oldest sample per cycle until there is room.
                    oldest_next = oldest_reg + IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    wr_en = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    k_next = '0;
                    res_next.vx = '0;
                    res_next.vy = '0;
                    res_next.vz = '0;
                    if (count_reg == '0)
                    begin
                        res_next.src = SRC_FEW;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                // The newest entry always qualifies, so the scan ends.
                if ({1'b0, rd_t_reg} + 49'(window_us) >= {1'b0, cur_reg.t})
                begin
                    pick_next = IDX_W'(oldest_reg + IDX_W'(k_reg));
                    if ({1'b0, cur_reg.t} < {1'b0, rd_t_reg} + {1'b0, DT_MIN_US})
                    begin
                        res_next.src = SRC_SMALL_DT;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        dt_next = cur_reg.t - rd_t_reg;
                        axis_next = 2'd0;
                        d_next = (Q_W+1)'(cur_reg.px) - (Q_W+1)'($signed(rd_x_reg));
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PICK_RD:
            begin
                rd_addr = pick_reg;
                state_next = ST_PICK_WAIT;
            end
            ST_PICK_WAIT:
            begin
                if (axis_reg == 2'd1)
                begin
                    d_next = (Q_W+1)'(cur_reg.py) - (Q_W+1)'($signed(rd_y_reg));
                end
                else
                begin
                    d_next = (Q_W+1)'(cur_reg.pz) - (Q_W+1)'($signed(rd_z_reg));
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                neg_next = d_reg[Q_W];
                mag_next = 52'(dmag) * 52'(US_PER_S);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (div_done)
                begin
                    res_next.sat = res_reg.sat | div_sat;
                    case (axis_reg)
                        2'd0: res_next.vx = div_quo;
                        2'd1: res_next.vy = div_quo;
                        default: res_next.vz = div_quo;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        res_next.src = SRC_DIFF;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                        state_next = ST_PICK_RD;
                    end
                end
            end
            ST_OUT:
            begin
                // The result moves to the output register so that the working
                // copy is free for the next request.
                if (!out_valid_reg || out_ready)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        out_reg <= out_next;
        dt_reg <= dt_next;
        d_reg <= d_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        k_reg <= k_next;
        pick_reg <= pick_next;
        axis_reg <= axis_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oldest_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oldest_reg <= oldest_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WDV_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(HISTORY_DEPTH), "history count exceeds depth")
    `WDV_ASSERT(a_out_hold, clk, rst_n, (out_valid_reg && !out_ready) |=> $stable(out_reg), "result changed while stalled")
    `WDV_ASSERT(a_scan_nonempty, clk, rst_n, (state_reg == ST_SCAN_CHK) |-> (k_reg < count_reg), "scan ran past stored samples")

endmodule
